FILE: hdl/sgp_pkg.sv
// ----------------------------------------------------------------------------
// sgp_pkg: shared types, constants and exp tables for the SiLU gated product
// Holds the channel payload structs, the item record passed from the front
// to the back, and the two constant exp(-x) tables built at elaboration.
// ----------------------------------------------------------------------------
package sgp_pkg;

  localparam int DATA_W       = 16;
  localparam int FRAC_W       = DATA_W / 2;
  localparam int WHOLE_W      = DATA_W - FRAC_W;
  localparam int SERIES_TERMS = 30;
  localparam int FRAC_DEPTH   = 2 ** FRAC_W;
  // exp(-1)^n floors to zero well before n reaches this depth.
  localparam int PWR_DEPTH    = 64;
  localparam int PWR_IDX_W    = $clog2(PWR_DEPTH);
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  localparam int EXP_W        = 63;             // Q2.62 values up to 1.0
  localparam int Q_FRAC       = 31;             // Q1.31 fraction bits
  localparam int SIG_W        = Q_FRAC + 1;     // sigmoid / exp in Q1.31
  localparam int DEN_W        = SIG_W + 1;
  localparam int DVD_W        = SIG_W + Q_FRAC;
  localparam int PROD_W       = 2 * DATA_W;
  localparam int PART_W       = DATA_W + SIG_W;
  localparam int SUM_W        = PROD_W + SIG_W;
  localparam int SCALE_SH     = Q_FRAC + FRAC_W;
  localparam int MAG_W        = SUM_W - SCALE_SH;

  localparam logic [63:0] ONE_Q62 = 64'd1 << 62;
  localparam logic [SIG_W-1:0] ONE_Q31 = SIG_W'(1) << Q_FRAC;
  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] gate_value;
    logic signed [DATA_W-1:0] up_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] product_value;
    logic                     saturated;
  } out_item_t;

  // Classified item: magnitudes, table indexes and signs.
  typedef struct packed {
    logic [DATA_W-1:0]    gate_mag;
    logic [DATA_W-1:0]    up_mag;
    logic [PWR_IDX_W-1:0] whole_idx;
    logic [FRAC_W-1:0]    frac;
    logic                 gate_neg;
    logic                 prod_neg;
  } cls_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Payload carried alongside the divider.
  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic              prod_neg;
  } div_tag_t;

  typedef logic [63:0] frac_tbl_t [FRAC_DEPTH];
  typedef logic [63:0] pwr_tbl_t [PWR_DEPTH];

  // Floored product of two Q2.62 values that are not above 1.0.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[125:62];
  endfunction

  // exp(-r / 2^FRAC_W) in Q2.62 by the truncated Taylor series.
  function automatic logic [63:0] exp_neg_small(input logic [63:0] r);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] whole;
    logic [63:0] part;
    sum  = ONE_Q62;
    term = ONE_Q62;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      whole = term >> FRAC_W;
      part  = term & ((64'd1 << FRAC_W) - 64'd1);
      term  = (whole * r + ((part * r) >> FRAC_W)) / 64'(k);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic frac_tbl_t build_frac_tbl();
    frac_tbl_t t;
    for (int i = 0; i < FRAC_DEPTH; i++) begin
      t[i] = exp_neg_small(64'(i));
    end
    return t;
  endfunction

  function automatic pwr_tbl_t build_pwr_tbl();
    pwr_tbl_t t;
    logic [63:0] e1;
    e1   = exp_neg_small(64'd1 << FRAC_W);
    t[0] = ONE_Q62;
    for (int i = 1; i < PWR_DEPTH; i++) begin
      t[i] = mul_q62(t[i-1], e1);
    end
    return t;
  endfunction

  localparam frac_tbl_t FRAC_EXP_TBL = build_frac_tbl();
  localparam pwr_tbl_t  PWR_EXP_TBL  = build_pwr_tbl();

endpackage

FILE: hdl/sgp_front.sv
// ----------------------------------------------------------------------------
// sgp_front: input stage of the SiLU gated product
// Accepts input transactions, splits the operands into sign and magnitude and
// forms the exp table indexes, then hands the record to the queue.
// ----------------------------------------------------------------------------
module sgp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sgp_pkg::in_item_t    in_data,
  input  logic                 q_full,
  output logic                 push,
  output sgp_pkg::cls_item_t   push_item
);
  import sgp_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  cls_item_t   item_r;
  cls_item_t   item_nxt;
  logic        accept;
  logic [DATA_W-1:0] g_bits;
  logic [DATA_W-1:0] u_bits;
  logic [WHOLE_W-1:0] whole;

  assign push     = valid_r && !q_full;
  assign in_stall = valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push_item = item_r;

  always_comb begin
    g_bits = in_data.gate_value;
    u_bits = in_data.up_value;
    item_nxt.gate_neg = g_bits[DATA_W-1];
    item_nxt.prod_neg = g_bits[DATA_W-1] ^ u_bits[DATA_W-1];
    item_nxt.gate_mag = g_bits[DATA_W-1] ? (~g_bits + 1'b1) : g_bits;
    item_nxt.up_mag   = u_bits[DATA_W-1] ? (~u_bits + 1'b1) : u_bits;
    whole = item_nxt.gate_mag[DATA_W-1:FRAC_W];
    // Beyond the table the exp chain is already zero.
    if (whole > WHOLE_W'(PWR_DEPTH - 1)) begin
      item_nxt.whole_idx = PWR_IDX_W'(PWR_DEPTH - 1);
    end else begin
      item_nxt.whole_idx = whole[PWR_IDX_W-1:0];
    end
    item_nxt.frac = item_nxt.gate_mag[FRAC_W-1:0];
  end

  assign valid_nxt = accept || (valid_r && !push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: hdl/sgp_queue.sv
// ----------------------------------------------------------------------------
// sgp_queue: short queue between the front and the back
// A small register queue that lets the front keep accepting while the back
// is held by a stalled receiver.
// ----------------------------------------------------------------------------
module sgp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sgp_pkg::cls_item_t push_item,
  input  logic               pop,
  output sgp_pkg::cls_item_t head_item,
  output sgp_pkg::q_stat_t   stat
);
  import sgp_pkg::*;

  cls_item_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic [Q_CNT_W-1:0]   cnt_nxt;

  assign head_item  = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: hdl/sgp_div.sv
// ----------------------------------------------------------------------------
// sgp_div: pipelined divider for the sigmoid
// Computes round(num * 2^31 / den) with one restoring quotient bit per stage,
// carrying the item payload alongside.
// ----------------------------------------------------------------------------
module sgp_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [sgp_pkg::SIG_W-1:0] in_num,
  input  logic [sgp_pkg::DEN_W-1:0] in_den,
  input  sgp_pkg::div_tag_t         in_tag,
  output logic                      out_valid,
  output logic [sgp_pkg::SIG_W-1:0] out_quo,
  output sgp_pkg::div_tag_t         out_tag
);
  import sgp_pkg::*;

  localparam int STEPS = SIG_W;

  logic [STEPS:0]     vld_r;
  logic [SIG_W-1:0]   rem_r [STEPS+1];
  logic [STEPS-1:0]   low_r [STEPS+1];
  logic [SIG_W-1:0]   quo_r [STEPS+1];
  logic [DEN_W-1:0]   den_r [STEPS+1];
  div_tag_t           tag_r [STEPS+1];
  logic [DVD_W-1:0]   dividend;
  logic [SIG_W:0]     shifted [STEPS];
  logic [SIG_W:0]     diff [STEPS];
  logic [STEPS-1:0]   take;

  // Adding half the divisor first gives round half up.
  assign dividend = {in_num, {Q_FRAC{1'b0}}} + DVD_W'(in_den >> 1);

  always_comb begin
    for (int i = 0; i < STEPS; i++) begin
      shifted[i] = {rem_r[i], low_r[i][STEPS-1]};
      diff[i]    = shifted[i] - den_r[i];
      take[i]    = (shifted[i] >= den_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= SIG_W'(dividend[DVD_W-1:STEPS]);
      low_r[0] <= dividend[STEPS-1:0];
      quo_r[0] <= '0;
      den_r[0] <= in_den;
      tag_r[0] <= in_tag;
      for (int i = 0; i < STEPS; i++) begin
        rem_r[i+1] <= take[i] ? diff[i][SIG_W-1:0] : shifted[i][SIG_W-1:0];
        low_r[i+1] <= low_r[i] << 1;
        quo_r[i+1] <= {quo_r[i][SIG_W-2:0], take[i]};
        den_r[i+1] <= den_r[i];
        tag_r[i+1] <= tag_r[i];
      end
    end
  end

  assign out_valid = vld_r[STEPS];
  assign out_quo   = quo_r[STEPS];
  assign out_tag   = tag_r[STEPS];

endmodule

FILE: hdl/sgp_back.sv
// ----------------------------------------------------------------------------
// sgp_back: arithmetic pipeline of the SiLU gated product
// Looks up exp(-|gate|), forms the sigmoid through the divider, scales the
// gate and up product, rounds and saturates into the output register.
// ----------------------------------------------------------------------------
module sgp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sgp_pkg::cls_item_t head_item,
  input  sgp_pkg::q_stat_t   q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output sgp_pkg::out_item_t out_data
);
  import sgp_pkg::*;

  localparam int PRE_STAGES = 5;
  localparam logic [MAG_W-1:0] HALF_RANGE = MAG_W'(2 ** (DATA_W - 1));
  localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(1) << (SCALE_SH - 1);

  logic                    adv;
  logic [PRE_STAGES-1:0]   pre_vld_r;
  div_tag_t                pre_tag_r [PRE_STAGES];
  logic [PRE_STAGES-1:0]   gneg_r;

  logic [EXP_W-1:0]        pwr_r;
  logic [EXP_W-1:0]        frx_r;
  logic [63:0]             pp_ll_r;
  logic [63:0]             pp_lh_r;
  logic [63:0]             pp_hl_r;
  logic [63:0]             pp_hh_r;
  logic [63:0]             mid_r;
  logic [63:0]             ll_r;
  logic [63:0]             hh_r;
  logic [127:0]            full_prod;
  logic [EXP_W-1:0]        e62_r;
  logic [63:0]             e31_rnd;
  logic [SIG_W-1:0]        e31_r;

  logic [SIG_W-1:0]        div_num;
  logic [DEN_W-1:0]        div_den;
  logic                    d_vld;
  logic [SIG_W-1:0]        d_quo;
  div_tag_t                d_tag;

  logic                    m1_vld_r;
  logic [PART_W-1:0]       pl_r;
  logic [PART_W-1:0]       ph_r;
  logic                    m1_neg_r;
  logic [SUM_W-1:0]        sum;
  logic                    m2_vld_r;
  logic [MAG_W-1:0]        mag_r;
  logic                    m2_neg_r;

  logic                    out_valid_r;
  out_item_t               out_data_r;
  out_item_t               out_data_nxt;
  logic                    res_neg;

  // The whole back advances together; it holds while a result waits.
  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r   <= '0;
      m1_vld_r    <= 1'b0;
      m2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      pre_vld_r   <= {pre_vld_r[PRE_STAGES-2:0], pop};
      m1_vld_r    <= d_vld;
      m2_vld_r    <= m1_vld_r;
      out_valid_r <= m2_vld_r;
    end
  end

  // exp(-|gate|) = exp(-1)^whole * exp(-frac), product split at bit 32 into parts.
  assign full_prod = {hh_r, ll_r} + {32'd0, mid_r, 32'd0};
  assign e31_rnd   = {1'b0, e62_r} + (64'd1 << (Q_FRAC - 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      pwr_r <= PWR_EXP_TBL[head_item.whole_idx][EXP_W-1:0];
      frx_r <= FRAC_EXP_TBL[head_item.frac][EXP_W-1:0];
      pre_tag_r[0].prod     <= PROD_W'(head_item.gate_mag) * PROD_W'(head_item.up_mag);
      pre_tag_r[0].prod_neg <= head_item.prod_neg;
      gneg_r[0]             <= head_item.gate_neg;
      for (int i = 1; i < PRE_STAGES; i++) begin
        pre_tag_r[i] <= pre_tag_r[i-1];
        gneg_r[i]    <= gneg_r[i-1];
      end

      pp_ll_r <= pwr_r[31:0] * frx_r[31:0];
      pp_lh_r <= pwr_r[31:0] * frx_r[EXP_W-1:32];
      pp_hl_r <= pwr_r[EXP_W-1:32] * frx_r[31:0];
      pp_hh_r <= pwr_r[EXP_W-1:32] * frx_r[EXP_W-1:32];

      mid_r <= pp_lh_r + pp_hl_r;
      ll_r  <= pp_ll_r;
      hh_r  <= pp_hh_r;

      e62_r <= full_prod[EXP_W+61:62];
      e31_r <= e31_rnd[62:31];
    end
  end

  // sigmoid = 1/(1+e) for a positive gate, e/(1+e) for a negative one.
  assign div_num = gneg_r[PRE_STAGES-1] ? e31_r : ONE_Q31;
  assign div_den = {1'b0, ONE_Q31} + {1'b0, e31_r};

  sgp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (pre_vld_r[PRE_STAGES-1]),
    .in_num    (div_num),
    .in_den    (div_den),
    .in_tag    (pre_tag_r[PRE_STAGES-1]),
    .out_valid (d_vld),
    .out_quo   (d_quo),
    .out_tag   (d_tag)
  );

  assign sum = (SUM_W'(ph_r) << DATA_W) + SUM_W'(pl_r) + RND_HALF;

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_r     <= d_tag.prod[DATA_W-1:0] * d_quo;
      ph_r     <= d_tag.prod[PROD_W-1:DATA_W] * d_quo;
      m1_neg_r <= d_tag.prod_neg;
      mag_r    <= sum[SUM_W-1:SCALE_SH];
      m2_neg_r <= m1_neg_r;
    end
  end

  always_comb begin
    res_neg = m2_neg_r && (mag_r != '0);
    out_data_nxt.saturated = 1'b0;
    if (res_neg) begin
      if (mag_r > HALF_RANGE) begin
        out_data_nxt.product_value = SAT_MIN;
        out_data_nxt.saturated     = 1'b1;
      end else begin
        out_data_nxt.product_value = DATA_W'(~mag_r + 1'b1);
      end
    end else begin
      if (mag_r > HALF_RANGE - 1'b1) begin
        out_data_nxt.product_value = SAT_MAX;
        out_data_nxt.saturated     = 1'b1;
      end else begin
        out_data_nxt.product_value = mag_r[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/silu_gated_product.sv
// ----------------------------------------------------------------------------
// silu_gated_product: elementwise SwiGLU gate, silu(gate) * up in Q8.8
// Streams one gate and one up element per transaction and returns their
// SiLU gated product, rounded to nearest and saturated to 16 bits.
// ----------------------------------------------------------------------------
// Usage notes.
// The input channel (in_valid, in_stall, in_data) takes one gate and up pair
// per transaction; the result channel (out_valid, out_stall, out_data) gives
// exactly one result per input, in input order. Both channels complete a
// transaction on a rising edge with valid high and stall low.
// Throughput is one transaction per cycle as long as the receiver does not
// stall. A result passes through one front register, one queue slot, the
// exp table and split 64-bit multiply stages, a 32-stage divider that yields
// one sigmoid bit per stage, and the scale, round and output stages.
// The sigmoid divider is the deepest part of the pipeline.
// When the receiver stalls, the output register and the whole back pipeline
// hold; the front keeps taking transactions until the four-entry queue and
// the front register fill, and only then raises in_stall.
// Reset (rst_n low at a clock edge) empties the queue and clears all valid
// bits; no result is in flight afterwards. Data registers are not reset.
// ----------------------------------------------------------------------------
module silu_gated_product (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sgp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sgp_pkg::out_item_t out_data
);
  import sgp_pkg::*;

  logic        q_push;
  logic        q_pop;
  cls_item_t   q_in_item;
  cls_item_t   q_head_item;
  q_stat_t     q_stat;

  // Front: sign and magnitude split, exp table indexes.
  sgp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_stat.full),
    .push      (q_push),
    .push_item (q_in_item)
  );

  // Queue that decouples the front from a stalled back.
  sgp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .head_item (q_head_item),
    .stat      (q_stat)
  );

  // Back: exp, sigmoid division, scaling, rounding and saturation.
  sgp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_item (q_head_item),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The front must never write into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue written while full");

  // The back must never read from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  // The input is held off only because the queue is full.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_stat.full)
    else $error("input stalled with room in the queue");

  // A clamped result sits at one end of the range.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.product_value == SAT_MAX || out_data.product_value == SAT_MIN))
    else $error("saturated result not at a range limit");

endmodule

FILE: tb/tb_silu_gated_product.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_silu_gated_product: self-checking testbench for the SiLU gated product
// Drives gate and up pairs through the input channel, predicts each result
// with an exact fixed-point SiLU product of its own, and compares every
// returned transaction field by field, under random idling and a long
// receiver hold-off that backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_silu_gated_product;
  import sgp_pkg::*;

  // Fixed-point constants of the prediction, in 64-bit terms.
  localparam logic [63:0] Q62_ONE     = 64'd1 << 62;
  localparam logic [63:0] Q31_ONE     = 64'd1 << 31;
  localparam logic [63:0] FRAC_MASK   = (64'd1 << FRAC_W) - 64'd1;
  localparam logic [63:0] HALF_RANGE  = 64'd1 << (DATA_W - 1);
  localparam int          PROD_SHIFT  = 31 + FRAC_W;
  localparam int          TAYLOR_LEN  = 30;

  localparam int NUM_ROWS      = 25;
  localparam int ITEMS_PER_RUN = 535;   // random transactions in each idling phase
  localparam int HOLD_CYCLES   = 200;   // long receiver hold-off for back pressure
  localparam int DRAIN_CYCLES  = 60;    // wait after the last expected result for stray results
  localparam int REPORT_LIMIT  = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Expected results of accepted transactions, oldest first.
  out_item_t pending_products [$];

  int error_count     = 0;
  int accepted_count  = 0;
  int result_count    = 0;
  int sat_count       = 0;
  int stalled_cycles  = 0;
  int recv_idle_pct   = 0;
  int hold_requests   = 0;
  int holds_served;
  int hold_left;

  // A directed row carries its expected result only when it is obvious.
  typedef struct packed {
    logic [DATA_W-1:0] gate;
    logic [DATA_W-1:0] up;
    logic              known;
    logic [DATA_W-1:0] product;
    logic              sat;
  } stim_row_t;

  stim_row_t stim_table [NUM_ROWS];

  silu_gated_product uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Floored product of two Q2.62 fractions.
  function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wide;
    wide = {64'd0, a} * {64'd0, b};
    wide = wide >> 62;
    return wide[63:0];
  endfunction

  // exp(-steps / 2^FRAC_W) in Q2.62 for steps up to one whole unit. Every
  // term is floored exactly as the hardware series is, so results match bit
  // for bit rather than approximately.
  function automatic logic [63:0] exp_series(input logic [63:0] steps);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = Q62_ONE;
    term = Q62_ONE;
    for (int k = 1; k <= TAYLOR_LEN; k++) begin
      term = ((term >> FRAC_W) * steps + (((term & FRAC_MASK) * steps) >> FRAC_W)) / 64'(k);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // silu(gate) * up in Q8.8, rounded half up and saturated.
  function automatic out_item_t predict_gated_product(input in_item_t item);
    logic signed [63:0] g;
    logic signed [63:0] u;
    logic [63:0] ga;
    logic [63:0] ua;
    logic [63:0] whole;
    logic [63:0] step;
    logic [63:0] e_one;
    logic [63:0] decay;
    logic [63:0] e62;
    logic [63:0] e31;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] sig;
    logic [63:0] mag;
    logic [63:0] neg_mag;
    logic [127:0] scaled;
    logic neg;
    out_item_t res;
    g  = $signed(item.gate_value);
    u  = $signed(item.up_value);
    ga = (g < 0) ? -g : g;
    ua = (u < 0) ? -u : u;
    // exp(-|g|) is exp(-1) raised to the whole part times exp(-fraction).
    whole = ga >> FRAC_W;
    e_one = exp_series(64'd1 << FRAC_W);
    decay = Q62_ONE;
    step  = 64'd0;
    while (step < whole && decay != 64'd0) begin
      decay = q62_product(decay, e_one);
      step  = step + 64'd1;
    end
    e62 = q62_product(decay, exp_series(ga & FRAC_MASK));
    e31 = (e62 + (64'd1 << 30)) >> 31;
    den = Q31_ONE + e31;
    num = (g < 0) ? e31 : Q31_ONE;
    sig = ((num << 31) + (den >> 1)) / den;
    scaled = {64'd0, ga * ua} * {64'd0, sig} + (128'd1 << (PROD_SHIFT - 1));
    scaled = scaled >> PROD_SHIFT;
    mag = scaled[63:0];
    neg = ((g < 0) != (u < 0)) && (mag != 64'd0);
    res.saturated = 1'b0;
    if (neg) begin
      if (mag > HALF_RANGE) begin
        mag = HALF_RANGE;
        res.saturated = 1'b1;
      end
      neg_mag = -mag;
      res.product_value = neg_mag[DATA_W-1:0];
    end else begin
      if (mag > HALF_RANGE - 64'd1) begin
        mag = HALF_RANGE - 64'd1;
        res.saturated = 1'b1;
      end
      res.product_value = mag[DATA_W-1:0];
    end
    return res;
  endfunction

  // Operands lean toward the range where SiLU bends, with extremes and fully
  // random words mixed in so every bit toggles.
  function automatic logic [DATA_W-1:0] pick_operand();
    int unsigned roll;
    logic [31:0] raw;
    roll = $urandom_range(0, 99);
    raw  = $urandom;
    if (roll < 45) begin
      raw = $urandom_range(0, 4095) - 32'd2048;
    end else if (roll < 55) begin
      case ($urandom_range(0, 4))
        0: raw = 32'h0000_7FFF;
        1: raw = 32'h0000_8000;
        2: raw = 32'h0000_0000;
        3: raw = 32'h0000_0001;
        default: raw = 32'h0000_FFFF;
      endcase
    end else if (roll < 70) begin
      raw = $urandom_range(0, 16383) - 32'd8192;
    end
    return raw[DATA_W-1:0];
  endfunction

  // Present one transaction and hold it until the block takes it. The
  // expectation is queued at the accepting edge; afterwards the sender goes
  // quiet with the given chance in each cycle.
  task automatic offer_item(input in_item_t item, input logic known,
                            input out_item_t known_result, input int idle_pct);
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pending_products.push_back(known ? known_result : predict_gated_product(item));
    accepted_count++;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) begin
        @(posedge clk);
      end
    end
  endtask

  task automatic run_random(input int count, input int idle_pct);
    in_item_t item;
    out_item_t unused;
    unused = '0;
    for (int i = 0; i < count; i++) begin
      item.gate_value = pick_operand();
      item.up_value   = pick_operand();
      offer_item(item, 1'b0, unused, idle_pct);
    end
  endtask

  // Receiver side. A long hold-off, once requested, is counted down in
  // hold_left; otherwise the receiver stalls at the current rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall    <= 1'b0;
      hold_left    <= 0;
      holds_served <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES - 1;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result checker. Every completed result transaction is matched against
  // the oldest expectation; values are read before this edge's updates land.
  always @(posedge clk) begin
    out_item_t expected;
    if (rst_n && in_valid && in_stall) begin
      stalled_cycles++;
    end
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (out_data.saturated === 1'b1) begin
        sat_count++;
      end
      if (pending_products.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("[%0t] unexpected result: product %0d saturated %0b", $realtime,
                   out_data.product_value, out_data.saturated);
        end
      end else begin
        expected = pending_products.pop_front();
        if (out_data.product_value !== expected.product_value ||
            out_data.saturated !== expected.saturated) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("[%0t] result %0d mismatch: product exp %0d got %0d, sat exp %0b got %0b",
                     $realtime, result_count, expected.product_value,
                     out_data.product_value, expected.saturated, out_data.saturated);
          end
        end
      end
    end
  end

  // Watchdog: ends a run that hangs and reports it as failed.
  initial begin
    #(5_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    out_item_t known_result;
    in_item_t  item;

    // Directed rows. Zero operands, the most negative gate (whose exp chain
    // floors to zero) and the two overflow corners are typed in; the rest
    // come from the predictor.
    stim_table = '{
      '{16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0},
      '{16'h0000, 16'h7FFF, 1'b1, 16'h0000, 1'b0},
      '{16'h0000, 16'h8000, 1'b1, 16'h0000, 1'b0},
      '{16'h7FFF, 16'h0000, 1'b1, 16'h0000, 1'b0},
      '{16'h8000, 16'h0000, 1'b1, 16'h0000, 1'b0},
      '{16'h8000, 16'h7FFF, 1'b1, 16'h0000, 1'b0},
      '{16'h8000, 16'h8000, 1'b1, 16'h0000, 1'b0},
      '{16'h8000, 16'hFFFF, 1'b1, 16'h0000, 1'b0},
      '{16'h7FFF, 16'h7FFF, 1'b1, SAT_MAX,  1'b1},
      '{16'h7FFF, 16'h8000, 1'b1, SAT_MIN,  1'b1},
      '{16'h0100, 16'h0100, 1'b0, 16'h0000, 1'b0},
      '{16'hFF00, 16'h0100, 1'b0, 16'h0000, 1'b0},
      '{16'h0001, 16'h0001, 1'b0, 16'h0000, 1'b0},
      '{16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
      '{16'hFFFF, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
      '{16'h0001, 16'h8000, 1'b0, 16'h0000, 1'b0},
      '{16'h7FFF, 16'hFF00, 1'b0, 16'h0000, 1'b0},
      '{16'h7FFF, 16'h0100, 1'b0, 16'h0000, 1'b0},
      '{16'h0800, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
      '{16'hF800, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
      '{16'h0200, 16'h8000, 1'b0, 16'h0000, 1'b0},
      '{16'hAAAA, 16'h5555, 1'b0, 16'h0000, 1'b0},
      '{16'h5555, 16'hAAAA, 1'b0, 16'h0000, 1'b0},
      '{16'hE000, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
      '{16'hF000, 16'h8000, 1'b0, 16'h0000, 1'b0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    recv_idle_pct <= 49;
    @(posedge clk);

    // First phase: the sender idles now and then, the receiver often.
    for (int i = 0; i < NUM_ROWS; i++) begin
      item.gate_value            = stim_table[i].gate;
      item.up_value              = stim_table[i].up;
      known_result.product_value = stim_table[i].product;
      known_result.saturated     = stim_table[i].sat;
      offer_item(item, stim_table[i].known, known_result, 21);
    end
    run_random(ITEMS_PER_RUN, 21);

    // Second phase: the roles are swapped.
    recv_idle_pct <= 21;
    run_random(ITEMS_PER_RUN, 49);

    // Third phase: nobody idles, except that the receiver first holds off for
    // a long stretch while the sender keeps offering, so the pipeline and its
    // queue fill and the block has to stall its input.
    recv_idle_pct <= 0;
    hold_requests <= hold_requests + 1;
    run_random(ITEMS_PER_RUN, 0);
    in_valid <= 1'b0;

    while (pending_products.size() != 0) begin
      @(posedge clk);
    end
    // Any stray result after the last expected one is caught by the checker.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d transactions (%0d directed) and %0d results, %0d saturated.",
             accepted_count, NUM_ROWS, result_count, sat_count);
    $display("The input was held off for %0d cycles under receiver back pressure.",
             stalled_cycles);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/sgp_pkg.sv
hdl/sgp_front.sv
hdl/sgp_queue.sv
hdl/sgp_div.sv
hdl/sgp_back.sv
hdl/silu_gated_product.sv
tb/tb_silu_gated_product.sv
